@@ rtl/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg
// Types and constants shared by the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int CW       = 32;           // coordinate width
    localparam int NW       = 18;           // normal component width
    localparam int PW       = NW + CW;      // product width
    localparam int DW       = 52;           // signed distance width
    localparam int MW       = 52;           // distance magnitude width
    localparam int RW       = MW + 2;       // partial remainder width
    localparam int STEPS    = CW;           // one quotient digit per stage
    localparam int LERP_LAT = STEPS + 1;    // divider stages plus output add
    localparam int IDXW     = 8;            // config index width

    localparam logic [IDXW-1:0] REG_NX  = IDXW'(0);
    localparam logic [IDXW-1:0] REG_NY  = IDXW'(1);
    localparam logic [IDXW-1:0] REG_NZ  = IDXW'(2);
    localparam logic [IDXW-1:0] REG_OFF = IDXW'(3);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_ONE,
        MODE_TWO,
        MODE_ALL
    } mode_t;

    typedef struct packed {
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } vert_t;

    typedef struct packed {
        logic [CW-1:0] color;
        vert_t         c;
        vert_t         b;
        vert_t         a;
    } tri_t;

    typedef struct packed {
        vert_t               a;
        logic [2:0]          neg;
        logic [2:0][CW-1:0]  dmag;
        logic [MW-1:0]       num;
        logic [MW-1:0]       den;
    } lerp_in_t;

endpackage

@@ rtl/tpc_lerp.sv @@
// ----------------------------------------------------------------------------
// tpc_lerp
// Pipelined edge intersection for one vertex pair: a + (b-a)*num/den per
// coordinate, one radix-2 digit per stage, truncated toward zero.
// ----------------------------------------------------------------------------
module tpc_lerp
(
    input  logic              clk,
    input  logic              en,
    input  tpc_pkg::lerp_in_t in,
    output tpc_pkg::vert_t    res
);
    import tpc_pkg::*;

    typedef struct packed {
        lerp_in_t            l;
        logic [2:0][MW-1:0]  rem;
        logic [2:0][CW-1:0]  q;
    } lstep_t;

    lstep_t st_reg  [STEPS];
    lstep_t st_next [STEPS];
    vert_t  res_reg;
    vert_t  res_next;

    always_comb
    begin
        lstep_t            src;
        logic [RW-1:0]     t;
        logic [RW-1:0]     den1;
        logic [RW-1:0]     den2;
        logic [CW:0]       qn;
        logic [1:0]        dig;
        for (int k = 0; k < STEPS; k++)
        begin
            if (k == 0)
            begin
                src.l   = in;
                src.rem = '0;
                src.q   = '0;
            end
            else
            begin
                src = st_reg[k-1];
            end
            den1 = RW'(src.l.den);
            den2 = RW'({src.l.den, 1'b0});
            st_next[k] = src;
            for (int j = 0; j < 3; j++)
            begin
                t = {1'b0, src.rem[j], 1'b0};
                if (src.l.dmag[j][CW-1])
                    t = t + RW'(src.l.num);
                if (t >= den2)
                begin
                    t   = t - den2;
                    dig = 2'd2;
                end
                else if (t >= den1)
                begin
                    t   = t - den1;
                    dig = 2'd1;
                end
                else
                begin
                    dig = 2'd0;
                end
                qn = {src.q[j], 1'b0} + (CW+1)'(dig);
                st_next[k].rem[j]  = t[MW-1:0];
                st_next[k].q[j]    = qn[CW-1:0];
                st_next[k].l.dmag[j] = {src.l.dmag[j][CW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic signed [CW+1:0] s [3];
        logic signed [CW+1:0] qs [3];
        lstep_t               f;
        f = st_reg[STEPS-1];
        for (int j = 0; j < 3; j++)
        begin
            qs[j] = $signed({2'b00, f.q[j]});
            if (f.l.neg[j])
                qs[j] = -qs[j];
        end
        s[0] = (CW+2)'(f.l.a.x) + qs[0];
        s[1] = (CW+2)'(f.l.a.y) + qs[1];
        s[2] = (CW+2)'(f.l.a.z) + qs[2];
        res_next.x = s[0][CW-1:0];
        res_next.y = s[1][CW-1:0];
        res_next.z = s[2][CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STEPS; k++)
                st_reg[k] <= st_next[k];
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/triangle_plane_clipper_core.sv @@
// ----------------------------------------------------------------------------
// triangle_plane_clipper_core
// Clips one triangle against a configured plane; emits zero, one or two
// triangles per input.
// ----------------------------------------------------------------------------
// Throughput: one input per cycle while m_tready holds and each input yields at most
// one triangle; an input that yields two stalls the pipeline until the second is taken.
// The pipeline advances as a whole; the 32-stage digit divider sets latency.
// Reset: asynchronous, active low; plane resets to normal (0,0,1), offset 0.
module triangle_plane_clipper_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [319:0]              s_tdata,   // ax,ay,az,bx,by_coord,bz,cx,cy,cz,tri_color
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [319:0]              m_tdata,   // out_ax..out_cz,out_color
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tpc_pkg::IDXW-1:0]  cfg_index,
    input  logic [31:0]               cfg_data
);
    import tpc_pkg::*;

    typedef struct packed {
        logic valid;
        tri_t t;
    } s0_t;

    typedef struct packed {
        logic                        valid;
        tri_t                        t;
        logic [2:0][2:0][PW-1:0]     p;
        logic [CW-1:0]               off;
    } s1_t;

    typedef struct packed {
        logic                 valid;
        tri_t                 t;
        logic [2:0][DW-1:0]   d;
    } s2_t;

    typedef struct packed {
        logic                 valid;
        mode_t                mode;
        logic [2:0][1:0]      r;
        tri_t                 t;
        logic [2:0][DW-1:0]   d;
    } s3_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
        tri_t  t;
    } side_t;

    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [CW-1:0] off_reg;

    logic     adv;
    s0_t      s0_reg, s0_next;
    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    s3_t      s3_reg, s3_next;
    side_t    s4_reg, s4_next;
    lerp_in_t l0_reg, l0_next, l1_reg, l1_next;
    side_t    sb_reg [LERP_LAT];
    vert_t    x0, x1;

    logic     ov_reg, ov_next;
    logic     pend2_reg, pend2_next;
    tri_t     cur_reg, cur_next, nxt_reg, nxt_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= NW'(65536);
            off_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NX:  nx_reg  <= cfg_data[NW-1:0];
                REG_NY:  ny_reg  <= cfg_data[NW-1:0];
                REG_NZ:  nz_reg  <= cfg_data[NW-1:0];
                REG_OFF: off_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register frees up
    assign adv      = !ov_reg || (m_tready && !pend2_reg);
    assign s_tready = adv;

    always_comb
    begin
        s0_next.valid = s_tvalid;
        s0_next.t     = tri_t'(s_tdata);
    end

    always_comb
    begin
        vert_t v [3];
        v[0] = s0_reg.t.a;
        v[1] = s0_reg.t.b;
        v[2] = s0_reg.t.c;
        s1_next.valid = s0_reg.valid;
        s1_next.t     = s0_reg.t;
        s1_next.off   = off_reg;
        for (int i = 0; i < 3; i++)
        begin
            s1_next.p[i][0] = PW'(nx_reg) * PW'(v[i].x);
            s1_next.p[i][1] = PW'(ny_reg) * PW'(v[i].y);
            s1_next.p[i][2] = PW'(nz_reg) * PW'(v[i].z);
        end
    end

    always_comb
    begin
        logic signed [DW-1:0] offs;
        offs = DW'($signed({s1_reg.off, 16'h0000}));
        s2_next.valid = s1_reg.valid;
        s2_next.t     = s1_reg.t;
        for (int i = 0; i < 3; i++)
        begin
            s2_next.d[i] = DW'($signed(s1_reg.p[i][0])) + DW'($signed(s1_reg.p[i][1]))
                         + DW'($signed(s1_reg.p[i][2])) + offs;
        end
    end

    // stable ranks, inside count
    always_comb
    begin
        logic signed [DW-1:0] d0, d1, d2;
        logic [1:0]           rk [3];
        logic [1:0]           ins;
        d0 = s2_reg.d[0];
        d1 = s2_reg.d[1];
        d2 = s2_reg.d[2];
        rk[0] = 2'(d1 < d0) + 2'(d2 < d0);
        rk[1] = 2'(d0 <= d1) + 2'(d2 < d1);
        rk[2] = 2'(d0 <= d2) + 2'(d1 <= d2);
        ins   = 2'(!d0[DW-1]) + 2'(!d1[DW-1]) + 2'(!d2[DW-1]);
        for (int k = 0; k < 3; k++)
        begin
            if (rk[0] == 2'(k))
                s3_next.r[k] = 2'd0;
            else if (rk[1] == 2'(k))
                s3_next.r[k] = 2'd1;
            else
                s3_next.r[k] = 2'd2;
        end
        case ((!d0[DW-1] && !d1[DW-1] && !d2[DW-1]) ? 2'd3 : ins)
            2'd0:    s3_next.mode = MODE_NONE;
            2'd1:    s3_next.mode = MODE_ONE;
            2'd2:    s3_next.mode = MODE_TWO;
            default: s3_next.mode = MODE_ALL;
        endcase
        s3_next.valid = s2_reg.valid;
        s3_next.t     = s2_reg.t;
        s3_next.d     = s2_reg.d;
    end

    // pick vertex pairs, set up divider operands
    always_comb
    begin
        vert_t                v [3];
        logic [1:0]           p0, q0, p1, q1;
        logic signed [DW:0]   den0, den1;
        logic signed [CW:0]   df;
        v[0] = s3_reg.t.a;
        v[1] = s3_reg.t.b;
        v[2] = s3_reg.t.c;
        if (s3_reg.mode == MODE_TWO)
        begin
            p0 = s3_reg.r[1];
            q0 = s3_reg.r[0];
            p1 = s3_reg.r[2];
            q1 = s3_reg.r[0];
        end
        else
        begin
            p0 = s3_reg.r[2];
            q0 = s3_reg.r[0];
            p1 = s3_reg.r[2];
            q1 = s3_reg.r[1];
        end
        s4_next.valid   = s3_reg.valid;
        s4_next.mode    = s3_reg.mode;
        s4_next.t       = s3_reg.t;
        if (s3_reg.mode != MODE_ALL)
        begin
            s4_next.t.a = v[p0];
            s4_next.t.b = v[p1];
        end
        den0 = (DW+1)'($signed(s3_reg.d[p0])) - (DW+1)'($signed(s3_reg.d[q0]));
        den1 = (DW+1)'($signed(s3_reg.d[p1])) - (DW+1)'($signed(s3_reg.d[q1]));
        l0_next.a   = v[p0];
        l1_next.a   = v[p1];
        l0_next.num = s3_reg.d[p0][MW-1:0];
        l1_next.num = s3_reg.d[p1][MW-1:0];
        l0_next.den = den0[MW-1:0];
        l1_next.den = den1[MW-1:0];
        for (int j = 0; j < 3; j++)
        begin
            df = (CW+1)'($signed(v[q0][j*CW +: CW])) - (CW+1)'($signed(v[p0][j*CW +: CW]));
            l0_next.neg[j]  = df[CW];
            l0_next.dmag[j] = df[CW] ? CW'(-df) : df[CW-1:0];
            df = (CW+1)'($signed(v[q1][j*CW +: CW])) - (CW+1)'($signed(v[p1][j*CW +: CW]));
            l1_next.neg[j]  = df[CW];
            l1_next.dmag[j] = df[CW] ? CW'(-df) : df[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            for (int k = 0; k < LERP_LAT; k++)
                sb_reg[k] <= '0;
        end
        else if (adv)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            sb_reg[0] <= s4_reg;
            for (int k = 1; k < LERP_LAT; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l0_reg <= l0_next;
            l1_reg <= l1_next;
        end
    end

    tpc_lerp u_lerp0
    (
        .clk (clk),
        .en  (adv),
        .in  (l0_reg),
        .res (x0)
    );

    tpc_lerp u_lerp1
    (
        .clk (clk),
        .en  (adv),
        .in  (l1_reg),
        .res (x1)
    );

    // output register, two triangles go out on consecutive requests
    always_comb
    begin
        side_t f;
        f          = sb_reg[LERP_LAT-1];
        ov_next    = ov_reg;
        pend2_next = pend2_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        if (adv)
        begin
            ov_next         = f.valid && (f.mode != MODE_NONE);
            pend2_next      = f.valid && (f.mode == MODE_TWO);
            cur_next        = f.t;
            nxt_next.color  = f.t.color;
            nxt_next.a      = x0;
            nxt_next.b      = f.t.b;
            nxt_next.c      = x1;
            case (f.mode)
                MODE_ONE:
                begin
                    cur_next.b = x0;
                    cur_next.c = x1;
                end
                MODE_TWO:
                begin
                    cur_next.c = x0;
                end
                default: ;
            endcase
        end
        else if (m_tready && pend2_reg)
        begin
            cur_next   = nxt_reg;
            pend2_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg    <= 1'b0;
            pend2_reg <= 1'b0;
        end
        else
        begin
            ov_reg    <= ov_next;
            pend2_reg <= pend2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        nxt_reg <= nxt_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = cur_reg;
    assign m_tlast  = !pend2_reg;

    a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend2_reg |-> ov_reg)
        else $error("second triangle pending without valid output");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("first of two triangles not followed by the last");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(sb_reg[LERP_LAT-1].valid))
        else $error("pipeline tail moved during stall");

endmodule
